/* sv/lcfp_pkg.sv */
// Shared types and constants of the lighting command field parser.
package lcfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CtrlW   = 16;
  localparam int unsigned AccW    = 24;
  localparam int unsigned TdataOW = 96;

  localparam logic [ByteW-1:0] CmdType   = 8'h01;
  localparam logic [1:0]       FadeGiven = 2'd2;

  // One parsed message.
  typedef struct packed {
    logic [1:0]  fade_mode;
    logic [7:0]  fade_time;
    logic [15:0] brightness_value;
    logic        brightness_is_percent;
    logic [15:0] colour_temperature;
    logic [23:0] timer_value;
    logic [15:0] hold_time;
    logic [7:0]  power_memory;
  } lcfp_result_t;

  // Status of the input register toward the parser.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             last;
  } lcfp_in_t;

endpackage

/* sv/lcfp_in_stage.sv */
// Input register that holds one byte item until the parser takes it.
module lcfp_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [lcfp_pkg::ByteW-1:0] s_axis_tdata,
  input  logic                       s_axis_tlast,
  input  logic                       adv_i,
  output lcfp_pkg::lcfp_in_t         in_o
);

  logic                       valid_q, valid_d;
  logic [lcfp_pkg::ByteW-1:0] data_q;
  logic                       last_q;
  logic                       load;

  assign s_axis_tready = !valid_q || adv_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  assign in_o = '{valid: valid_q, data: data_q, last: last_q};

endmodule

/* sv/lcfp_parser.sv */
// Parse state and the one-byte step of the message parser.
module lcfp_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [lcfp_pkg::ByteW-1:0] byte_i,
  input  logic                       last_i,
  output logic                       res_valid_o,
  output lcfp_pkg::lcfp_result_t     res_o,
  output logic                       hdr_phase_o
);

  localparam logic [2:0] PhHdr  = 3'd0;
  localparam logic [2:0] PhFade = 3'd1;
  localparam logic [2:0] PhBri  = 3'd2;
  localparam logic [2:0] PhCt   = 3'd3;
  localparam logic [2:0] PhTail = 3'd4;
  localparam logic [2:0] PhSkip = 3'd5;

  logic [2:0]                 ph_q, ph_d;
  logic [1:0]                 idx_q, idx_d, idx_inc, tail_len;
  logic [lcfp_pkg::CtrlW-1:0] cw_q, cw_d;
  logic [lcfp_pkg::AccW-1:0]  acc_q, acc_d;
  logic [7:0]                 fade_q, fade_d;
  logic [16:0]                bri_q, bri_d;
  logic [15:0]                ct_q, ct_d;
  logic                       drop_q, drop_d;
  logic                       cut;
  logic                       tail_ok;

  // First phase at or after from that the control word asks for.
  function automatic logic [2:0] next_phase(input logic [2:0] from,
                                            input logic [15:0] cw);
    logic [2:0] ph;
    ph = PhSkip;
    priority if (from <= PhFade && cw[15:14] == lcfp_pkg::FadeGiven) begin
      ph = PhFade;
    end else if (from <= PhBri && cw[13]) begin
      ph = PhBri;
    end else if (from <= PhCt && cw[12]) begin
      ph = PhCt;
    end else if (from <= PhTail && (cw[4] || cw[5] || cw[6])) begin
      ph = PhTail;
    end
    return ph;
  endfunction

  assign tail_len = cw_q[4] ? 2'd3 : (cw_q[5] ? 2'd2 : 2'd1);
  assign idx_inc  = idx_q + 2'd1;

  always_comb begin
    ph_d   = ph_q;
    idx_d  = idx_q;
    cw_d   = cw_q;
    acc_d  = acc_q;
    fade_d = fade_q;
    bri_d  = bri_q;
    ct_d   = ct_q;
    drop_d = drop_q;
    cut    = 1'b0;
    unique case (ph_q)
      PhHdr: begin
        if (idx_q == 2'd0) begin
          if (byte_i != lcfp_pkg::CmdType) drop_d = 1'b1;
          idx_d = 2'd1;
        end else if (idx_q == 2'd1) begin
          cw_d  = {byte_i, 8'h00};
          idx_d = 2'd2;
        end else begin
          cw_d  = {cw_q[15:8], byte_i};
          ph_d  = next_phase(PhFade, cw_d);
          idx_d = 2'd0;
          acc_d = '0;
        end
      end
      PhFade: begin
        fade_d = byte_i;
        ph_d   = next_phase(PhBri, cw_q);
        idx_d  = 2'd0;
        acc_d  = '0;
      end
      PhBri: begin
        if (idx_q == 2'd0 && byte_i[7]) begin
          bri_d = {1'b1, 9'd0, byte_i[6:0]};
          ph_d  = next_phase(PhCt, cw_q);
          idx_d = 2'd0;
          acc_d = '0;
        end else if (idx_q == 2'd0) begin
          acc_d = {16'd0, byte_i};
          idx_d = 2'd1;
        end else begin
          bri_d = {1'b0, acc_q[7:0], byte_i};
          ph_d  = next_phase(PhCt, cw_q);
          idx_d = 2'd0;
          acc_d = '0;
        end
      end
      PhCt: begin
        if (idx_q == 2'd0) begin
          // percentage form still needs a byte after it
          cut = last_i;
          if (byte_i[7]) begin
            ct_d  = {9'd0, byte_i[6:0]};
            ph_d  = next_phase(PhTail, cw_q);
            idx_d = 2'd0;
            acc_d = '0;
          end else begin
            acc_d = {16'd0, byte_i};
            idx_d = 2'd1;
          end
        end else begin
          ct_d  = {acc_q[7:0], byte_i};
          ph_d  = next_phase(PhTail, cw_q);
          idx_d = 2'd0;
          acc_d = '0;
        end
      end
      PhTail: begin
        acc_d = {acc_q[15:0], byte_i};
        if (idx_inc >= tail_len) begin
          ph_d  = PhSkip;
          idx_d = 2'd0;
        end else begin
          idx_d = idx_inc;
        end
      end
      default: begin
      end
    endcase
  end

  assign tail_ok = (ph_d == PhSkip);

  assign res_valid_o = last_i && !(cut || drop_d || ph_d == PhHdr || ph_d == PhBri ||
                                   ph_d == PhCt ||
                                   (ph_d == PhFade && (cw_d[13] || cw_d[12])));

  always_comb begin
    res_o.fade_mode             = cw_d[15:14];
    res_o.fade_time             = (cw_d[15:14] == lcfp_pkg::FadeGiven) ? fade_d : 8'd0;
    res_o.brightness_value      = cw_d[13] ? bri_d[15:0] : 16'd0;
    res_o.brightness_is_percent = cw_d[13] && bri_d[16];
    res_o.colour_temperature    = cw_d[12] ? ct_d : 16'd0;
    res_o.timer_value           = (cw_d[4] && tail_ok) ? acc_d : 24'd0;
    res_o.hold_time             = (!cw_d[4] && cw_d[5] && tail_ok) ? acc_d[15:0] : 16'd0;
    res_o.power_memory          = (!cw_d[4] && !cw_d[5] && cw_d[6] && tail_ok) ?
                                  acc_d[7:0] : 8'd0;
  end

  // A final byte returns all parse state to its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhHdr;
      idx_q  <= 2'd0;
      cw_q   <= '0;
      acc_q  <= '0;
      fade_q <= '0;
      bri_q  <= '0;
      ct_q   <= '0;
      drop_q <= 1'b0;
    end else if (adv_i) begin
      if (last_i) begin
        ph_q   <= PhHdr;
        idx_q  <= 2'd0;
        cw_q   <= '0;
        acc_q  <= '0;
        fade_q <= '0;
        bri_q  <= '0;
        ct_q   <= '0;
        drop_q <= 1'b0;
      end else begin
        ph_q   <= ph_d;
        idx_q  <= idx_d;
        cw_q   <= cw_d;
        acc_q  <= acc_d;
        fade_q <= fade_d;
        bri_q  <= bri_d;
        ct_q   <= ct_d;
        drop_q <= drop_d;
      end
    end
  end

  assign hdr_phase_o = (ph_q == PhHdr) && (idx_q == 2'd0);

endmodule

/* sv/light_command_field_parser.sv */
// Light command field parser: one byte item per cycle unless m_axis stalls, at most
// one result per message. Takes one message byte per cycle on s_axis while m_axis
// is not stalled, tlast on the final byte, with no gaps needed between messages. A
// byte is held in the input register and is parsed on its way into the result
// register, from which a message's result shows on m_axis; a message that is
// dropped (wrong type, under three bytes, brightness or colour temperature cut
// short) gives no result. The sustained rate is one byte per cycle while m_axis
// is not stalled, set by the single parse step between the two registers;
// s_axis_tready follows m_axis_tready combinationally while both registers are full.
module light_command_field_parser #(
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] fade_mode, [9:2] fade_time, [25:10] brightness_value,
  // [41:26] colour_temperature, [65:42] timer_value, [81:66] hold_time,
  // [89:82] power_memory, [95:90] zero
  output logic [lcfp_pkg::TdataOW-1:0] m_axis_tdata,
  output logic        m_axis_tuser    // brightness_is_percent
);

  lcfp_pkg::lcfp_in_t     in_s;
  lcfp_pkg::lcfp_result_t res;
  lcfp_pkg::lcfp_result_t res_q;
  logic                   res_valid;
  logic                   hdr_phase;
  logic                   adv;
  logic                   out_valid_q, out_valid_d;
  logic                   out_free;
  logic                   out_load;

  assign out_free = !out_valid_q || m_axis_tready;
  assign adv      = in_s.valid && out_free;
  assign out_load = adv && res_valid;

  lcfp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .adv_i        (adv),
    .in_o         (in_s)
  );

  lcfp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .byte_i     (in_s.data),
    .last_i     (in_s.last),
    .res_valid_o(res_valid),
    .res_o      (res),
    .hdr_phase_o(hdr_phase)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) out_valid_d = out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) res_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.brightness_is_percent;
  assign m_axis_tdata  = {6'd0, res_q.power_memory, res_q.hold_time, res_q.timer_value,
                          res_q.colour_temperature, res_q.brightness_value,
                          res_q.fade_time, res_q.fade_mode};

  // A result is loaded only from a final byte.
  a_result_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> in_s.last)
    else $error("result loaded from a byte that is not final");

  // A final byte restarts parsing at the type byte.
  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_s.last) |=> hdr_phase)
    else $error("parser not back at header after final byte");

  // Back-pressure on the input only while the input register holds a byte.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_s.valid |-> s_axis_tready)
    else $error("input stalled with an empty input register");

  // A stalled result is not overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !adv)
    else $error("parser advanced while the result register was stalled");

endmodule
